>>> hw/rtl/pbet_pkg.sv
// Shared types and constants for the pointer and button event tracker.
package pbet_pkg;

    localparam int COORD_W  = 12;
    localparam int DELTA_W  = 12;
    localparam int REPEAT_W = 16;
    localparam int TICKS_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 48;

    localparam logic [COORD_W-1:0]  RST_SCREEN_LEFT   = 12'd0;
    localparam logic [COORD_W-1:0]  RST_SCREEN_TOP    = 12'd0;
    localparam logic [COORD_W-1:0]  RST_SCREEN_RIGHT  = 12'd639;
    localparam logic [COORD_W-1:0]  RST_SCREEN_BOTTOM = 12'd479;
    localparam logic [REPEAT_W-1:0] RST_REPEAT_TICKS  = 16'd250;

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_REPORT = 2'd1,
        KIND_SETPOS = 2'd2,
        KIND_NOP    = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_LEFT   = 3'd0,
        CFG_SCREEN_TOP    = 3'd1,
        CFG_SCREEN_RIGHT  = 3'd2,
        CFG_SCREEN_BOTTOM = 3'd3,
        CFG_HOT_X         = 3'd4,
        CFG_HOT_Y         = 3'd5,
        CFG_REPEAT_TICKS  = 3'd6,
        CFG_TRACK_EN      = 3'd7
    } cfg_idx_t;

    // Per-button event flags, down in the lowest bit.
    typedef struct packed {
        logic up;
        logic held;
        logic down;
    } btn_flags_t;

endpackage

>>> hw/rtl/pointer_button_event_tracker.sv
// Pointer hotspot and two-button event tracker, top level.
//
// Input stream (s_*): one beat per item; s_tuser carries the item kind
// (tick, report, set position, or an unused code that just reports state).
// Output stream (m_*): exactly one result beat per input beat, showing the
// position, the latest button flags and the idle timer after that item.
// Configuration: cfg_we / cfg_addr / cfg_wdata write one register per
// clock; the user must write only while the block is idle (not enforced).
// Indices 4 and 5 (hotspot offset) are accepted and affect no result.
// Path: an accepted beat passes the input register, then the update logic
// into the result register, which drives m_tdata.
// Throughput: one item per cycle while m_tready stays high; the update path
// is one adder and clamp compare per axis plus button logic, all combinational.
// Stalls: while m_tready is low the result register holds and one more
// beat may wait in the input register; s_tready drops once both are full.
// Reset: asynchronous, clears state, timers and flags and loads the register
// defaults (640x480 window, repeat above 250 ticks, tracking off).
module pointer_button_event_tracker
    import pbet_pkg::*;
#(
    parameter int TIMER_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // delta_x[11:0], delta_y[23:12], left_pressed[24], right_pressed[25],
    // new_x[37:26], new_y[49:38], zero pad [55:50]
    input  logic [IN_DATA_W-1:0]   s_tdata,
    // kind[1:0]
    input  logic [1:0]             s_tuser,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // pointer_x[11:0], pointer_y[23:12], left_down[24], left_held[25],
    // left_released[26], right_down[27], right_held[28], right_released[29],
    // idle[30], idle_ticks[46:31], zero pad [47]
    output logic [OUT_DATA_W-1:0]  m_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

    // configuration
    logic [COORD_W-1:0]  scr_left_reg, scr_top_reg, scr_right_reg, scr_bottom_reg;
    logic [REPEAT_W-1:0] repeat_ticks_reg;
    logic                track_en_reg;

    // input stage
    logic                     in_valid_reg, in_valid_next;
    kind_t                    in_kind_reg;
    logic signed [DELTA_W-1:0] in_dx_reg, in_dy_reg;
    logic                     in_left_reg, in_right_reg;
    logic [COORD_W-1:0]       in_new_x_reg, in_new_y_reg;

    // tracker state
    logic [COORD_W-1:0]    hot_pos_x_reg, hot_pos_x_next;
    logic [COORD_W-1:0]    hot_pos_y_reg, hot_pos_y_next;
    logic                  prev_left_reg, prev_left_next;
    logic                  prev_right_reg, prev_right_next;
    btn_flags_t            left_flags_reg, left_flags_next;
    btn_flags_t            right_flags_reg, right_flags_next;
    logic [TIMER_BITS-1:0] left_cnt_reg, left_cnt_next;
    logic [TIMER_BITS-1:0] right_cnt_reg, right_cnt_next;
    logic                  idling_reg, idling_next;
    logic [TIMER_BITS-1:0] idle_cnt_reg, idle_cnt_next;

    // result register
    logic                  out_valid_reg, out_valid_next;
    logic [COORD_W-1:0]    out_x_reg, out_y_reg;
    btn_flags_t            out_left_reg, out_right_reg;
    logic                  out_idle_reg;
    logic [TICKS_W-1:0]    out_ticks_reg, out_ticks_next;

    logic s_accept, advance, fire;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign in_valid_next  = s_accept ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
    assign out_valid_next = fire ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_left_reg     <= RST_SCREEN_LEFT;
            scr_top_reg      <= RST_SCREEN_TOP;
            scr_right_reg    <= RST_SCREEN_RIGHT;
            scr_bottom_reg   <= RST_SCREEN_BOTTOM;
            repeat_ticks_reg <= RST_REPEAT_TICKS;
            track_en_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_SCREEN_LEFT:   scr_left_reg     <= cfg_wdata[COORD_W-1:0];
                CFG_SCREEN_TOP:    scr_top_reg      <= cfg_wdata[COORD_W-1:0];
                CFG_SCREEN_RIGHT:  scr_right_reg    <= cfg_wdata[COORD_W-1:0];
                CFG_SCREEN_BOTTOM: scr_bottom_reg   <= cfg_wdata[COORD_W-1:0];
                CFG_REPEAT_TICKS:  repeat_ticks_reg <= cfg_wdata[REPEAT_W-1:0];
                CFG_TRACK_EN:      track_en_reg     <= cfg_wdata[0];
                default:           ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_kind_reg  <= kind_t'(s_tuser);
            in_dx_reg    <= $signed(s_tdata[11:0]);
            in_dy_reg    <= $signed(s_tdata[23:12]);
            in_left_reg  <= s_tdata[24];
            in_right_reg <= s_tdata[25];
            in_new_x_reg <= s_tdata[37:26];
            in_new_y_reg <= s_tdata[49:38];
        end
    end

    // update logic
    logic                      moved, goes_idle;
    logic signed [COORD_W+1:0] sum_x, sum_y, clamp_in_x, clamp_in_y;
    logic [COORD_W-1:0]        clamped_x, clamped_y;
    btn_flags_t                left_new, right_new;
    logic                      left_clr, right_clr;

    assign moved     = (in_dx_reg != '0) || (in_dy_reg != '0);
    assign goes_idle = !moved && !in_left_reg && !in_right_reg
                       && !prev_left_reg && !prev_right_reg;

    assign sum_x = $signed({2'b00, hot_pos_x_reg}) + (COORD_W+2)'(in_dx_reg);
    assign sum_y = $signed({2'b00, hot_pos_y_reg}) + (COORD_W+2)'(in_dy_reg);
    assign clamp_in_x = (in_kind_reg == KIND_SETPOS) ? $signed({2'b00, in_new_x_reg}) : sum_x;
    assign clamp_in_y = (in_kind_reg == KIND_SETPOS) ? $signed({2'b00, in_new_y_reg}) : sum_y;

    pbet_clamp u_clamp_x
    (
        .pos     (clamp_in_x),
        .lo      (scr_left_reg),
        .hi      (scr_right_reg),
        .clamped (clamped_x)
    );

    pbet_clamp u_clamp_y
    (
        .pos     (clamp_in_y),
        .lo      (scr_top_reg),
        .hi      (scr_bottom_reg),
        .clamped (clamped_y)
    );

    pbet_button #(.TIMER_BITS(TIMER_BITS)) u_btn_left
    (
        .old_flags    (left_flags_reg),
        .level        (in_left_reg),
        .hold_count   (left_cnt_reg),
        .repeat_ticks (repeat_ticks_reg),
        .flags        (left_new),
        .clear_count  (left_clr)
    );

    pbet_button #(.TIMER_BITS(TIMER_BITS)) u_btn_right
    (
        .old_flags    (right_flags_reg),
        .level        (in_right_reg),
        .hold_count   (right_cnt_reg),
        .repeat_ticks (repeat_ticks_reg),
        .flags        (right_new),
        .clear_count  (right_clr)
    );

    always_comb
    begin
        hot_pos_x_next   = hot_pos_x_reg;
        hot_pos_y_next   = hot_pos_y_reg;
        prev_left_next   = prev_left_reg;
        prev_right_next  = prev_right_reg;
        left_flags_next  = left_flags_reg;
        right_flags_next = right_flags_reg;
        left_cnt_next    = left_cnt_reg;
        right_cnt_next   = right_cnt_reg;
        idling_next      = idling_reg;
        idle_cnt_next    = idle_cnt_reg;
        if (fire)
        begin
            case (in_kind_reg)
                KIND_TICK:
                begin
                    if (left_cnt_reg != TIMER_MAX)
                        left_cnt_next = left_cnt_reg + 1'b1;
                    if (right_cnt_reg != TIMER_MAX)
                        right_cnt_next = right_cnt_reg + 1'b1;
                    if (idling_reg && idle_cnt_reg != TIMER_MAX)
                        idle_cnt_next = idle_cnt_reg + 1'b1;
                end
                KIND_REPORT:
                begin
                    if (track_en_reg)
                    begin
                        if (goes_idle)
                        begin
                            if (!idling_reg)
                                idle_cnt_next = '0;
                            idling_next      = 1'b1;
                            left_flags_next  = '0;
                            right_flags_next = '0;
                        end
                        else
                        begin
                            idling_next      = 1'b0;
                            prev_left_next   = in_left_reg;
                            prev_right_next  = in_right_reg;
                            left_flags_next  = left_new;
                            right_flags_next = right_new;
                            if (left_clr)
                                left_cnt_next = '0;
                            if (right_clr)
                                right_cnt_next = '0;
                            if (moved)
                            begin
                                hot_pos_x_next = clamped_x;
                                hot_pos_y_next = clamped_y;
                            end
                        end
                    end
                end
                KIND_SETPOS:
                begin
                    hot_pos_x_next = clamped_x;
                    hot_pos_y_next = clamped_y;
                end
                default:
                    ;
            endcase
        end
    end

    // idle tick count on the 16-bit result field, saturating if the timer is wider
    generate
        if (TIMER_BITS > TICKS_W)
        begin : g_ticks_sat
            assign out_ticks_next = !idling_next ? '0 :
                ((idle_cnt_next[TIMER_BITS-1:TICKS_W] != '0) ? '1
                                                             : idle_cnt_next[TICKS_W-1:0]);
        end
        else
        begin : g_ticks_ext
            assign out_ticks_next = idling_next ? TICKS_W'(idle_cnt_next) : '0;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hot_pos_x_reg   <= '0;
            hot_pos_y_reg   <= '0;
            prev_left_reg   <= 1'b0;
            prev_right_reg  <= 1'b0;
            left_flags_reg  <= '0;
            right_flags_reg <= '0;
            left_cnt_reg    <= '0;
            right_cnt_reg   <= '0;
            idling_reg      <= 1'b0;
            idle_cnt_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            hot_pos_x_reg   <= hot_pos_x_next;
            hot_pos_y_reg   <= hot_pos_y_next;
            prev_left_reg   <= prev_left_next;
            prev_right_reg  <= prev_right_next;
            left_flags_reg  <= left_flags_next;
            right_flags_reg <= right_flags_next;
            left_cnt_reg    <= left_cnt_next;
            right_cnt_reg   <= right_cnt_next;
            idling_reg      <= idling_next;
            idle_cnt_reg    <= idle_cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_x_reg     <= hot_pos_x_next;
            out_y_reg     <= hot_pos_y_next;
            out_left_reg  <= left_flags_next;
            out_right_reg <= right_flags_next;
            out_idle_reg  <= idling_next;
            out_ticks_reg <= out_ticks_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_ticks_reg, out_idle_reg,
                       out_right_reg.up, out_right_reg.held, out_right_reg.down,
                       out_left_reg.up, out_left_reg.held, out_left_reg.down,
                       out_y_reg, out_x_reg};

    // a beat leaving the input register always lands in the result register
    a_fire_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("processed beat did not reach the result register");

    // leaving idle takes a report
    a_idle_exit: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(idling_reg) |-> $past(fire && in_kind_reg == KIND_REPORT && track_en_reg))
        else $error("idle state left without an enabled report");

    // position only moves when a beat is processed
    a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(hot_pos_x_reg) && $stable(hot_pos_y_reg))
        else $error("position changed without a beat");

    // the idle timer reads zero outside idle
    a_ticks_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_idle_reg) |-> (out_ticks_reg == '0))
        else $error("idle ticks reported while not idle");

endmodule

>>> hw/rtl/pbet_clamp.sv
// Clamp of one coordinate axis to a [lo, hi] window, low edge checked first.
module pbet_clamp
    import pbet_pkg::*;
(
    input  logic signed [COORD_W+1:0] pos,
    input  logic        [COORD_W-1:0] lo,
    input  logic        [COORD_W-1:0] hi,
    output logic        [COORD_W-1:0] clamped
);

    logic signed [COORD_W+1:0] lo_s;
    logic signed [COORD_W+1:0] hi_s;

    assign lo_s = $signed({2'b00, lo});
    assign hi_s = $signed({2'b00, hi});

    always_comb
    begin
        if (pos < lo_s)
            clamped = lo;
        else if (pos > hi_s)
            clamped = hi;
        else
            clamped = pos[COORD_W-1:0];
    end

endmodule

>>> hw/rtl/pbet_button.sv
// Down / held / released / autorepeat flag logic for one button.
module pbet_button
    import pbet_pkg::*;
#(
    parameter int TIMER_BITS = 16
)
(
    input  btn_flags_t              old_flags,
    input  logic                    level,
    input  logic [TIMER_BITS-1:0]   hold_count,
    input  logic [REPEAT_W-1:0]     repeat_ticks,
    output btn_flags_t              flags,
    output logic                    clear_count
);

    localparam int CMP_W = (TIMER_BITS > REPEAT_W) ? TIMER_BITS : REPEAT_W;

    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] rep_ext;
    logic             was_active;

    assign cnt_ext    = CMP_W'(hold_count);
    assign rep_ext    = CMP_W'(repeat_ticks);
    assign was_active = old_flags.down | old_flags.held;

    always_comb
    begin
        flags       = '0;
        clear_count = 1'b0;
        if (was_active)
        begin
            if (level)
            begin
                flags.held = 1'b1;
                if (cnt_ext > rep_ext)
                begin
                    flags.down  = 1'b1;
                    clear_count = 1'b1;
                end
            end
            else
            begin
                flags.up = 1'b1;
            end
        end
        else if (level)
        begin
            flags.down  = 1'b1;
            clear_count = 1'b1;
        end
    end

endmodule

>>> dv/tb_pointer_button_event_tracker.sv
// Self-checking testbench for the pointer and two-button event tracker.
`timescale 1ns / 1ps

module tb_pointer_button_event_tracker;
    import pbet_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        kind_t                     kind;
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic                      lp;
        logic                      rp;
        logic [COORD_W-1:0]        nx;
        logic [COORD_W-1:0]        ny;
    } item_t;

    typedef struct {
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        btn_flags_t         lf;
        btn_flags_t         rf;
        logic               idle;
        logic [TICKS_W-1:0] ticks;
    } result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [1:0]            s_tuser = KIND_TICK;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = CFG_SCREEN_LEFT;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    pointer_button_event_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // register shadow
    logic [COORD_W-1:0]  scr_left = RST_SCREEN_LEFT;
    logic [COORD_W-1:0]  scr_top = RST_SCREEN_TOP;
    logic [COORD_W-1:0]  scr_right = RST_SCREEN_RIGHT;
    logic [COORD_W-1:0]  scr_bottom = RST_SCREEN_BOTTOM;
    logic [REPEAT_W-1:0] rep_ticks = RST_REPEAT_TICKS;
    logic                track_en = 1'b0;

    // tracker state as predicted
    logic [COORD_W-1:0] pos_x = '0;
    logic [COORD_W-1:0] pos_y = '0;
    logic               prev_l = 1'b0;
    logic               prev_r = 1'b0;
    btn_flags_t         l_evt = '0;
    btn_flags_t         r_evt = '0;
    logic [TICKS_W-1:0] l_hold = '0;
    logic [TICKS_W-1:0] r_hold = '0;
    logic               is_idle = 1'b0;
    logic [TICKS_W-1:0] idle_cnt = '0;

    item_t   pending_items[$];
    result_t expected_results[$];
    item_t   offered;
    item_t   drv_item;
    result_t want;
    bit      in_taken = 1'b0;
    bit      gaps_on = 1'b1;
    bit      long_hold_req = 1'b0;
    bit      gen_left = 1'b0;
    bit      gen_right = 1'b0;
    int      send_gap = 0;
    int      recv_gap = 0;
    int      hold_cnt = 0;
    int      mismatch_count = 0;
    int      cycle_count = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [TICKS_W-1:0] sat_inc(input logic [TICKS_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    // below low edge wins over above high edge when the window is inverted
    function automatic logic [COORD_W-1:0] clamp_axis(input int p,
                                                      input logic [COORD_W-1:0] lo,
                                                      input logic [COORD_W-1:0] hi);
        int q;
        q = p;
        if (q < int'(lo))
            q = int'(lo);
        else if (q > int'(hi))
            q = int'(hi);
        return q[COORD_W-1:0];
    endfunction

    task automatic step_button(input btn_flags_t old, input logic level,
                               inout logic [TICKS_W-1:0] hold, output btn_flags_t f);
        f = '0;
        if (old.down || old.held)
        begin
            if (level)
            begin
                f.held = 1'b1;
                if (hold > rep_ticks)
                begin
                    f.down = 1'b1;
                    hold = '0;
                end
            end
            else
                f.up = 1'b1;
        end
        else if (level)
        begin
            f.down = 1'b1;
            hold = '0;
        end
    endtask

    task automatic track_pointer(input item_t it);
        result_t    r;
        int         dxi;
        int         dyi;
        logic       moved;
        btn_flags_t nl;
        btn_flags_t nr;
        dxi = int'(it.dx);
        dyi = int'(it.dy);
        moved = (dxi != 0) || (dyi != 0);
        case (it.kind)
            KIND_TICK:
            begin
                l_hold = sat_inc(l_hold);
                r_hold = sat_inc(r_hold);
                if (is_idle)
                    idle_cnt = sat_inc(idle_cnt);
            end
            KIND_REPORT:
            begin
                if (track_en)
                begin
                    if (!moved && !it.lp && !it.rp && !prev_l && !prev_r)
                    begin
                        if (!is_idle)
                        begin
                            idle_cnt = '0;
                            is_idle = 1'b1;
                        end
                        l_evt = '0;
                        r_evt = '0;
                    end
                    else
                    begin
                        is_idle = 1'b0;
                        prev_l = it.lp;
                        prev_r = it.rp;
                        step_button(l_evt, it.lp, l_hold, nl);
                        step_button(r_evt, it.rp, r_hold, nr);
                        l_evt = nl;
                        r_evt = nr;
                        if (moved)
                        begin
                            pos_x = clamp_axis(int'(pos_x) + dxi, scr_left, scr_right);
                            pos_y = clamp_axis(int'(pos_y) + dyi, scr_top, scr_bottom);
                        end
                    end
                end
            end
            KIND_SETPOS:
            begin
                pos_x = clamp_axis(int'(it.nx), scr_left, scr_right);
                pos_y = clamp_axis(int'(it.ny), scr_top, scr_bottom);
            end
            default: ;
        endcase
        r.px = pos_x;
        r.py = pos_y;
        r.lf = l_evt;
        r.rf = r_evt;
        r.idle = is_idle;
        r.ticks = is_idle ? idle_cnt : '0;
        expected_results.push_back(r);
    endtask

    task automatic log_mismatch(input string what);
        if (mismatch_count < 40)
            $display("[%0t] MISMATCH %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic cmp_field(input string name, input logic [15:0] got,
                             input logic [15:0] exp_val);
        if (got !== exp_val)
            log_mismatch($sformatf("%s: got %0h, want %0h", name, got, exp_val));
    endtask

    // input beat taken -> predict; output beat taken -> check
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                track_pointer(offered);
                in_taken = 1'b1;
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                    log_mismatch($sformatf("unexpected beat %h", m_tdata));
                else
                begin
                    want = expected_results.pop_front();
                    cmp_field("pointer_x", 16'(m_tdata[11:0]), 16'(want.px));
                    cmp_field("pointer_y", 16'(m_tdata[23:12]), 16'(want.py));
                    cmp_field("left_down", 16'(m_tdata[24]), 16'(want.lf.down));
                    cmp_field("left_held", 16'(m_tdata[25]), 16'(want.lf.held));
                    cmp_field("left_released", 16'(m_tdata[26]), 16'(want.lf.up));
                    cmp_field("right_down", 16'(m_tdata[27]), 16'(want.rf.down));
                    cmp_field("right_held", 16'(m_tdata[28]), 16'(want.rf.held));
                    cmp_field("right_released", 16'(m_tdata[29]), 16'(want.rf.up));
                    cmp_field("idle", 16'(m_tdata[30]), 16'(want.idle));
                    cmp_field("idle_ticks", m_tdata[46:31], want.ticks);
                end
            end
        end
    end

    // sender
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                drv_item = pending_items.pop_front();
                offered = drv_item;
                s_tdata <= {6'b0, drv_item.ny, drv_item.nx, drv_item.rp, drv_item.lp,
                            drv_item.dy, drv_item.dx};
                s_tuser <= drv_item.kind;
                s_tvalid <= 1'b1;
                if (gaps_on && $urandom_range(0, 4) == 0)
                    send_gap = $urandom_range(1, 3);
            end
            else
                s_tvalid <= 1'b0;
        end
        in_taken = 1'b0;
    end

    // receiver
    always @(negedge clk)
    begin
        if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            hold_cnt = 80;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            m_tready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap--;
            m_tready <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            recv_gap = $urandom_range(0, 2);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    task automatic push_item(input kind_t k, input int dx, input int dy, input int l,
                             input int r, input int nx, input int ny);
        item_t it;
        it.kind = k;
        it.dx = DELTA_W'(dx);
        it.dy = DELTA_W'(dy);
        it.lp = 1'(l);
        it.rp = 1'(r);
        it.nx = COORD_W'(nx);
        it.ny = COORD_W'(ny);
        pending_items.push_back(it);
    endtask

    task automatic push_ticks(input int n);
        repeat (n) push_item(KIND_TICK, 0, 0, 0, 0, 0, 0);
    endtask

    function automatic int rand_delta();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 4095);
        return $urandom_range(0, 32) - 16;
    endfunction

    // mostly reports and ticks with sticky button levels, some set-position and no-op
    task automatic gen_items(input int n);
        int    sel;
        kind_t k;
        int    dx;
        int    dy;
        repeat (n)
        begin
            sel = $urandom_range(0, 19);
            k = (sel < 7) ? KIND_TICK : (sel < 17) ? KIND_REPORT :
                (sel < 19) ? KIND_SETPOS : KIND_NOP;
            if ($urandom_range(0, 3) == 0)
                gen_left = !gen_left;
            if ($urandom_range(0, 3) == 0)
                gen_right = !gen_right;
            if ($urandom_range(0, 9) < 3)
            begin
                dx = 0;
                dy = 0;
            end
            else
            begin
                dx = rand_delta();
                dy = rand_delta();
            end
            push_item(k, dx, dy, int'(gen_left), int'(gen_right),
                      $urandom_range(0, 4095), $urandom_range(0, 4095));
        end
    endtask

    task automatic wait_drain();
        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SCREEN_LEFT:   scr_left = val[COORD_W-1:0];
            CFG_SCREEN_TOP:    scr_top = val[COORD_W-1:0];
            CFG_SCREEN_RIGHT:  scr_right = val[COORD_W-1:0];
            CFG_SCREEN_BOTTOM: scr_bottom = val[COORD_W-1:0];
            CFG_REPEAT_TICKS:  rep_ticks = val[REPEAT_W-1:0];
            CFG_TRACK_EN:      track_en = val[0];
            default: ;         // hotspot offset does not affect results
        endcase
    endtask

    task automatic load_setup(input int l, input int t, input int r, input int b,
                              input int hx, input int hy, input int rep, input int en);
        wait_drain();
        write_reg(CFG_SCREEN_LEFT, CFG_DATA_W'(l));
        write_reg(CFG_SCREEN_TOP, CFG_DATA_W'(t));
        write_reg(CFG_SCREEN_RIGHT, CFG_DATA_W'(r));
        write_reg(CFG_SCREEN_BOTTOM, CFG_DATA_W'(b));
        write_reg(CFG_HOT_X, CFG_DATA_W'(hx));
        write_reg(CFG_HOT_Y, CFG_DATA_W'(hy));
        write_reg(CFG_REPEAT_TICKS, CFG_DATA_W'(rep));
        write_reg(CFG_TRACK_EN, CFG_DATA_W'(en));
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // tracking off after reset: reports ignored, others still act
        push_item(KIND_REPORT, 5, 5, 1, 0, 0, 0);
        push_item(KIND_TICK, 0, 0, 0, 0, 0, 0);
        push_item(KIND_SETPOS, 0, 0, 0, 0, 4095, 4095);
        push_item(KIND_SETPOS, 0, 0, 0, 0, 0, 0);
        push_item(KIND_NOP, 0, 0, 0, 0, 0, 0);

        load_setup(0, 0, 639, 479, 255, 0, 1, 1);
        push_item(KIND_REPORT, 2047, 2047, 0, 0, 0, 0);
        push_item(KIND_REPORT, -2048, -2048, 0, 0, 0, 0);
        push_item(KIND_REPORT, 0, 0, 0, 0, 0, 0);       // enter idle
        push_item(KIND_TICK, 0, 0, 0, 0, 0, 0);
        push_item(KIND_TICK, 0, 0, 0, 0, 0, 0);
        push_item(KIND_REPORT, 0, 0, 0, 0, 0, 0);       // stays idle, timer kept
        push_item(KIND_REPORT, 0, 0, 1, 0, 0, 0);
        push_item(KIND_TICK, 0, 0, 0, 0, 0, 0);
        push_item(KIND_TICK, 0, 0, 0, 0, 0, 0);
        push_item(KIND_REPORT, 0, 0, 1, 0, 0, 0);       // autorepeat
        push_item(KIND_REPORT, 3, -3, 1, 1, 0, 0);
        push_item(KIND_REPORT, 0, 0, 0, 1, 0, 0);
        push_item(KIND_REPORT, 0, 0, 0, 0, 0, 0);
        push_item(KIND_REPORT, 0, 0, 0, 0, 0, 0);
        push_item(KIND_NOP, 0, 0, 0, 0, 0, 0);
        push_item(KIND_SETPOS, 0, 0, 0, 0, 100, 200);

        // inverted window
        load_setup(3000, 4095, 100, 0, 0, 255, 1, 1);
        push_item(KIND_SETPOS, 0, 0, 0, 0, 50, 4095);
        push_item(KIND_SETPOS, 0, 0, 0, 0, 3500, 10);
        push_item(KIND_REPORT, 1, 1, 0, 0, 0, 0);

        // large repeat thresholds: held buttons never repeat
        gaps_on = 1'b0;
        load_setup(0, 0, 639, 479, 1, 1, 65535, 1);
        push_item(KIND_REPORT, 0, 0, 1, 1, 0, 0);
        push_ticks(40);
        push_item(KIND_REPORT, 0, 0, 1, 1, 0, 0);
        load_setup(0, 0, 639, 479, 1, 1, 65534, 1);
        push_item(KIND_REPORT, 0, 0, 1, 1, 0, 0);
        push_item(KIND_REPORT, 0, 0, 0, 0, 0, 0);
        push_item(KIND_REPORT, 0, 0, 0, 0, 0, 0);
        push_ticks(40);
        push_item(KIND_NOP, 0, 0, 0, 0, 0, 0);
        gaps_on = 1'b1;

        load_setup($urandom_range(0, 200), $urandom_range(0, 200),
                   $urandom_range(600, 1200), $urandom_range(400, 900),
                   $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 8), 1);
        long_hold_req = 1'b1;
        gen_items(190);

        load_setup(0, 0, 4095, 4095, $urandom_range(0, 255), $urandom_range(0, 255), 0, 1);
        gen_items(190);

        load_setup(0, 0, 0, 0, $urandom_range(0, 255), $urandom_range(0, 255), 65535, 1);
        gen_items(190);

        load_setup($urandom_range(0, 4095), $urandom_range(0, 4095),
                   $urandom_range(0, 4095), $urandom_range(0, 4095),
                   $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 65535), 1);
        gen_items(190);

        load_setup($urandom_range(0, 4095), $urandom_range(0, 4095),
                   $urandom_range(0, 4095), $urandom_range(0, 4095),
                   $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 8), 0);
        gen_items(100);

        load_setup($urandom_range(0, 300), $urandom_range(0, 300),
                   $urandom_range(500, 4095), $urandom_range(500, 4095),
                   $urandom_range(0, 255), $urandom_range(0, 255), 3, 1);
        gaps_on = 1'b0;
        gen_items(190);

        wait_drain();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
